/* hw/rtl/lhrb_pkg.sv */
`default_nettype none

package lhrb_pkg;

	// command codes
	localparam logic [1:0] CMD_PUSH    = 2'd0;
	localparam logic [1:0] CMD_READ    = 2'd1;
	localparam logic [1:0] CMD_DISCARD = 2'd2;

	localparam logic [7:0] NEWLINE_BYTE = 8'h0A;

	typedef struct packed {
		logic [1:0] cmd;
		logic [7:0] data_byte;
		logic [5:0] line_limit;
		logic [4:0] line_pos;
		logic [6:0] byte_pos;
	} item_t;

	typedef struct packed {
		logic [5:0] lines_available;
		logic [7:0] read_byte;
		logic       byte_valid;
	} res_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_COPY,
		ST_RESULT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic accept;
		logic copy_step;
		logic commit;
		logic load_out;
	} ctl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic is_newline;
		logic copy_done;
		logic out_busy;
	} dp_status_t;

endpackage

`default_nettype wire

/* hw/rtl/lhrb_ctrl.sv */
`default_nettype none

module lhrb_ctrl
	import lhrb_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       item_valid,
	output logic            item_stall,
	input  wire dp_status_t status,
	output ctl_cmd_t        cmd
);

	state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d       = state_q;
		cmd           = '0;
		item_stall    = 1'b1;
		case (state_q)
			ST_IDLE: begin
				item_stall = 1'b0;
				if (item_valid) begin
					cmd.accept = 1'b1;
					state_d    = status.is_newline ? ST_COPY : ST_RESULT;
				end
			end
			ST_COPY: begin
				if (status.copy_done) begin
					cmd.commit = 1'b1;
					state_d    = ST_RESULT;
				end else begin
					cmd.copy_step = 1'b1;
				end
			end
			ST_RESULT: begin
				if (!status.out_busy) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

/* hw/rtl/lhrb_datapath.sv */
`default_nettype none

module lhrb_datapath
	import lhrb_pkg::*;
#(
	parameter int RING_LINES = 32,
	parameter int LINE_LEN   = 128
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire item_t    item_data,
	input  wire ctl_cmd_t cmd,
	output dp_status_t    status,
	output logic          res_valid,
	input  wire logic     res_stall,
	output res_t          res_data
);

	localparam int LW = $clog2(LINE_LEN);
	localparam int SW = $clog2(RING_LINES);
	localparam int CW = $clog2(RING_LINES + 1);
	localparam int XW = CW + 6;
	localparam logic [LW:0]   LAST_POS  = (LW + 1)'(LINE_LEN - 1);
	localparam logic [CW-1:0] FULL_CNT  = CW'(RING_LINES);
	localparam logic [SW-1:0] LAST_SLOT = SW'(RING_LINES - 1);
	localparam logic [XW:0]   RING_X    = (XW + 1)'(RING_LINES);

	// storage
	logic [7:0]    store_mem   [RING_LINES][LINE_LEN];
	logic [LW-1:0] lengths_mem [RING_LINES];
	logic [7:0]    partial_mem [LINE_LEN];

	// line state
	logic [LW-1:0] partial_len_q;
	logic          zero_seen_q;
	logic [LW-1:0] cut_len_q;
	logic [CW-1:0] stored_count_q;
	logic [SW-1:0] next_slot_q;

	// copy pipeline
	logic [LW-1:0] rd_ptr_q;
	logic          pend_s1;
	logic [LW-1:0] wptr_s1;
	logic [7:0]    pdata_s1;

	// item and read data
	item_t         item_q;
	logic [LW-1:0] len_rd_q;
	logic [7:0]    byte_rd_q;
	res_t          res_q;
	logic          res_valid_q;

	logic [LW-1:0] eff_len;
	logic          push_store;
	logic [SW-1:0] rd_slot;
	logic [LW-1:0] rd_byte_idx;
	logic [LW+6:0] bpos_x;
	res_t          res_d;

	function automatic logic [XW-1:0] avail(input logic [CW-1:0] cnt, input logic [5:0] lim);
		logic [XW-1:0] c;
		logic [XW-1:0] l;
		c = XW'(cnt);
		l = XW'(lim);
		return (c < l) ? c : l;
	endfunction

	assign eff_len    = zero_seen_q ? cut_len_q : partial_len_q;
	assign push_store = cmd.accept && item_data.cmd == CMD_PUSH
		&& item_data.data_byte != NEWLINE_BYTE && {1'b0, partial_len_q} < LAST_POS;

	// ring index of the requested line, oldest first
	always_comb begin
		logic [XW-1:0] n_x;
		logic [XW-1:0] skip_x;
		logic [XW:0]   sum_x;
		n_x    = avail(stored_count_q, item_data.line_limit);
		skip_x = XW'(stored_count_q) - n_x;
		sum_x  = (XW + 1)'(skip_x) + (XW + 1)'(item_data.line_pos);
		if (stored_count_q == FULL_CNT) begin
			sum_x = sum_x + (XW + 1)'(next_slot_q);
		end
		if (sum_x >= RING_X) begin
			sum_x = sum_x - RING_X;
		end
		rd_slot = sum_x[SW-1:0];
	end

	assign bpos_x      = (LW + 7)'(item_data.byte_pos);
	assign rd_byte_idx = bpos_x[LW-1:0];

	assign status.is_newline = item_data.cmd == CMD_PUSH && item_data.data_byte == NEWLINE_BYTE;
	assign status.copy_done  = rd_ptr_q == eff_len && !pend_s1;
	assign status.out_busy   = res_valid_q && res_stall;

	// partial line memory
	always_ff @(posedge clk) begin
		if (push_store) begin
			partial_mem[partial_len_q] <= item_data.data_byte;
		end
		if (cmd.copy_step) begin
			pdata_s1 <= partial_mem[rd_ptr_q];
		end
	end

	// line store memory
	always_ff @(posedge clk) begin
		if (pend_s1) begin
			store_mem[next_slot_q][wptr_s1] <= pdata_s1;
		end
		if (cmd.accept) begin
			byte_rd_q <= store_mem[rd_slot][rd_byte_idx];
		end
	end

	// line length memory
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			lengths_mem[next_slot_q] <= eff_len;
		end
		if (cmd.accept) begin
			len_rd_q <= lengths_mem[rd_slot];
		end
	end

	// item and zero cut position
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			item_q <= item_data;
		end
		if (push_store && item_data.data_byte == 8'd0 && !zero_seen_q) begin
			cut_len_q <= partial_len_q;
		end
		if (cmd.copy_step) begin
			wptr_s1 <= rd_ptr_q;
		end
	end

	// line control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			partial_len_q  <= '0;
			zero_seen_q    <= 1'b0;
			stored_count_q <= '0;
			next_slot_q    <= '0;
			rd_ptr_q       <= '0;
			pend_s1        <= 1'b0;
		end else begin
			if (push_store) begin
				partial_len_q <= partial_len_q + 1'b1;
				if (item_data.data_byte == 8'd0) begin
					zero_seen_q <= 1'b1;
				end
			end
			if (cmd.accept && item_data.cmd == CMD_DISCARD) begin
				partial_len_q <= '0;
				zero_seen_q   <= 1'b0;
			end
			if (cmd.accept) begin
				rd_ptr_q <= '0;
				pend_s1  <= 1'b0;
			end
			// copy one byte a cycle; each write uses the read data and pointer registered in pdata_s1 and wptr_s1
			if (cmd.copy_step) begin
				pend_s1 <= rd_ptr_q < eff_len;
				if (rd_ptr_q < eff_len) begin
					rd_ptr_q <= rd_ptr_q + 1'b1;
				end
			end
			if (cmd.commit) begin
				partial_len_q <= '0;
				zero_seen_q   <= 1'b0;
				next_slot_q   <= (next_slot_q == LAST_SLOT) ? '0 : next_slot_q + 1'b1;
				if (stored_count_q != FULL_CNT) begin
					stored_count_q <= stored_count_q + 1'b1;
				end
			end
		end
	end

	// result
	always_comb begin
		logic [XW-1:0] n_x;
		logic          hit;
		n_x = avail(stored_count_q, item_q.line_limit);
		hit = item_q.cmd == CMD_READ && XW'(item_q.line_pos) < n_x
			&& 9'(item_q.byte_pos) < 9'(len_rd_q);
		res_d.lines_available = n_x[5:0];
		res_d.byte_valid      = hit;
		res_d.read_byte       = hit ? byte_rd_q : 8'd0;
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			res_q <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	assign res_valid = res_valid_q;
	assign res_data  = res_q;

endmodule

`default_nettype wire

/* hw/rtl/line_history_ring_buffer.sv */
// Channel   Dir  Beat      Handshake
// item      in   item_t    item_valid / item_stall
// res       out  res_t     res_valid / res_stall
//
// Push, read and discard pass through accept, with memory reads, then result.
// A newline push copies the partial line into the ring one byte a cycle through
// the single read port, then drains the last write and commits.
// arst_n clears counters and handshake state; memories are not cleared.
// A held result in the output register does not block acceptance of the next beat.
`default_nettype none

module line_history_ring_buffer
	import lhrb_pkg::*;
#(
	parameter int RING_LINES = 32,
	parameter int LINE_LEN   = 128
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  item_valid,
	output logic       item_stall,
	input  wire item_t item_data,
	output logic       res_valid,
	input  wire logic  res_stall,
	output res_t       res_data
);

	ctl_cmd_t   cmd;
	dp_status_t status;

	lhrb_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.status     (status),
		.cmd        (cmd)
	);

	lhrb_datapath #(
		.RING_LINES (RING_LINES),
		.LINE_LEN   (LINE_LEN)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_data (item_data),
		.cmd       (cmd),
		.status    (status),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_data  (res_data)
	);

endmodule

`default_nettype wire
